FILE: design/md5de_pkg.sv
// Package with MD5 constants, tables and shared types for the digest engine.
`default_nettype none
package md5de_pkg;

    localparam logic [31:0] C_IV_A = 32'h67452301;
    localparam logic [31:0] C_IV_B = 32'hefcdab89;
    localparam logic [31:0] C_IV_C = 32'h98badcfe;
    localparam logic [31:0] C_IV_D = 32'h10325476;
    localparam logic [7:0]  C_PAD_BYTE = 8'h80;
    localparam int          QueueDepth = 4;
    localparam int          QueuePtrW = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    function automatic logic [31:0] f_round_add(input logic [5:0] j);
        logic [31:0] r;
        begin
            unique case (j)
                6'd0: r = 32'hd76aa478; 6'd1: r = 32'he8c7b756; 6'd2: r = 32'h242070db;
                6'd3: r = 32'hc1bdceee; 6'd4: r = 32'hf57c0faf; 6'd5: r = 32'h4787c62a;
                6'd6: r = 32'ha8304613; 6'd7: r = 32'hfd469501; 6'd8: r = 32'h698098d8;
                6'd9: r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
                6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
                6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
                6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
                6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
                6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
                6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
                6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
                6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
                6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
                6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
                6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
                6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
                6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
                6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
                6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
                6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
                6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
                default: r = 32'heb86d391;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] f_rot(input logic [3:0] k);
        logic [4:0] r;
        begin
            unique case (k)
                4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
                4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
                4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
                4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] f_msg_index(input logic [5:0] j);
        logic [3:0] r;
        begin
            unique case (j[5:4])
                2'd0: r = j[3:0];
                2'd1: r = 4'(5 * j[3:0] + 1);
                2'd2: r = 4'(3 * j[3:0] + 5);
                default: r = 4'(7 * j[3:0]);
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/md5de_queue.sv
// Small first-in first-out queue that separates the input front from the compression back.
`default_nettype none
module md5de_queue
    import md5de_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);
    t_item               r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr;
    logic [QueuePtrW-1:0] r_rd;
    logic [QueuePtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (QueuePtrW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QueuePtrW+1)'(i_push && !o_full)
                           - (QueuePtrW+1)'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

FILE: design/md5de_core.sv
// Back end: block buffering, padding sequencer and one MD5 round per cycle.
`default_nettype none
module md5de_core
    import md5de_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_item_pop,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    logic [31:0]  r_blk [16];
    logic [31:0]  r_cv_a, r_cv_b, r_cv_c, r_cv_d;
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [60:0]  r_total;
    logic [5:0]   r_fill;
    logic [5:0]   r_round;
    logic         r_final;
    logic         r_last;
    logic [5:0]   r_pad_pos;

    logic [31:0]  w_f, w_sum, w_rot, w_msg;
    logic [4:0]   w_sh;
    logic [63:0]  w_bits;

    always_comb begin
        unique case (r_round[5:4])
            2'd0: w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1: w_f = (r_d & r_b) | (~r_d & r_c);
            2'd2: w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_msg = r_blk[f_msg_index(r_round)];
        w_sum = w_f + r_a + f_round_add(r_round) + w_msg;
        w_sh  = f_rot({r_round[5:4], r_round[1:0]});
        w_rot = (w_sum << w_sh) | (w_sum >> (6'd32 - {1'b0, w_sh}));
        w_bits = {r_total, 3'b000};
    end

    assign o_item_pop  = (r_state == S_IDLE) && i_item_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign o_digest_a  = r_cv_a;
    assign o_digest_b  = r_cv_b;
    assign o_digest_c  = r_cv_c;
    assign o_digest_d  = r_cv_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cv_a  <= C_IV_A;
            r_cv_b  <= C_IV_B;
            r_cv_c  <= C_IV_C;
            r_cv_d  <= C_IV_D;
            r_total <= '0;
            r_fill  <= '0;
            r_round <= '0;
            r_final <= 1'b0;
            r_last  <= 1'b0;
            r_pad_pos <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_final <= i_item.end_of_message;
                        if (i_item.has_byte) begin
                            r_fill  <= r_fill + 1'b1;
                            r_total <= r_total + 1'b1;
                        end
                        r_round <= '0;
                        r_last  <= 1'b0;
                        r_pad_pos <= i_item.has_byte ? r_fill + 1'b1 : r_fill;
                        r_a <= r_cv_a; r_b <= r_cv_b; r_c <= r_cv_c; r_d <= r_cv_d;
                    end
                end
                S_ROUND: begin
                    r_a <= r_d;
                    r_d <= r_c;
                    r_c <= r_b;
                    r_b <= r_b + w_rot;
                    r_round <= r_round + 1'b1;
                end
                S_ADD: begin
                    r_cv_a <= r_cv_a + r_a;
                    r_cv_b <= r_cv_b + r_b;
                    r_cv_c <= r_cv_c + r_c;
                    r_cv_d <= r_cv_d + r_d;
                end
                S_PAD: begin
                    r_round <= '0;
                    r_last  <= (r_pad_pos < 6'd56);
                end
                S_LEN: begin
                    r_round <= '0;
                    r_last  <= 1'b1;
                    r_a <= r_cv_a; r_b <= r_cv_b; r_c <= r_cv_c; r_d <= r_cv_d;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_cv_a  <= C_IV_A;
                        r_cv_b  <= C_IV_B;
                        r_cv_c  <= C_IV_C;
                        r_cv_d  <= C_IV_D;
                        r_total <= '0;
                        r_fill  <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (r_state == S_PAD) begin
                r_a <= r_cv_a; r_b <= r_cv_b; r_c <= r_cv_c; r_d <= r_cv_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_item_valid && i_item.has_byte) begin
            unique case (r_fill[1:0])
                2'd0: r_blk[r_fill[5:2]][7:0]   <= i_item.data_byte;
                2'd1: r_blk[r_fill[5:2]][15:8]  <= i_item.data_byte;
                2'd2: r_blk[r_fill[5:2]][23:16] <= i_item.data_byte;
                default: r_blk[r_fill[5:2]][31:24] <= i_item.data_byte;
            endcase
        end else if (r_state == S_PAD) begin
            for (int w = 0; w < 16; w++) begin
                if (w >= 14 && r_pad_pos < 6'd56) begin
                    r_blk[w] <= (w == 14) ? w_bits[31:0] : w_bits[63:32];
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        if (6'(4 * w + k) == r_pad_pos) begin
                            r_blk[w][8*k +: 8] <= C_PAD_BYTE;
                        end else if (6'(4 * w + k) > r_pad_pos) begin
                            r_blk[w][8*k +: 8] <= 8'h00;
                        end
                    end
                end
            end
        end else if (r_state == S_LEN) begin
            for (int w = 0; w < 14; w++) begin
                r_blk[w] <= '0;
            end
            r_blk[14] <= w_bits[31:0];
            r_blk[15] <= w_bits[63:32];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.has_byte && r_fill == 6'd63) begin
                        n_state = S_ROUND;
                    end else if (i_item.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                priority if (r_last) begin
                    n_state = S_OUT;
                end else if (r_final && r_round == 6'd0 && r_pad_pos == 6'd0 &&
                             !r_last) begin
                    n_state = S_PAD;
                end else if (r_final && r_pad_pos >= 6'd56) begin
                    n_state = S_LEN;
                end else if (r_final) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD:   n_state = S_ROUND;
            S_LEN:   n_state = S_ROUND;
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/md5_digest_engine_top.sv
// Top level of the MD5 digest engine: input queue followed by the compression back end.
// An item enters the queue when o_ready is high; a byte that fills a block starts a compression.
// A final item adds one or two compressions, then the output state S_OUT, held until i_ready.
// The queue keeps taking items while a block is compressed, until its four entries are full.
// Synchronous active-low reset restores the MD5 initial words and clears all counts.
`default_nettype none
module md5_digest_engine_top
    import md5de_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_a,
    output logic [31:0]      o_digest_b,
    output logic [31:0]      o_digest_c,
    output logic [31:0]      o_digest_d
);
    t_item w_in, w_head;
    logic  w_full, w_empty, w_pop;

    assign w_in = '{data_byte: i_data_byte, has_byte: i_has_byte,
                    end_of_message: i_end_of_message};
    assign o_ready = !w_full;

    md5de_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (w_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    md5de_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!w_empty),
        .i_item       (w_head),
        .o_item_pop   (w_pop),
        .o_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .o_digest_a   (o_digest_a),
        .o_digest_b   (o_digest_b),
        .o_digest_c   (o_digest_c),
        .o_digest_d   (o_digest_d)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_a))
        else $error("digest changed while stalled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_pop)
        else $error("item taken while digest pending");
endmodule
`default_nettype wire
